// ===== rtl/tcc_pkg.sv =====
// ----------------------------------------------------------------------------
// Terminal cursor controller package
// Field widths, command codes, scroll event codes and register indexes.
// ----------------------------------------------------------------------------
package tcc_pkg;

   localparam int MAX_COLUMNS = 256;
   localparam int MAX_ROWS    = 256;
   localparam int TAB_STEP    = 8;

   localparam int COL_WIDTH   = 9;
   localparam int ROW_WIDTH   = 8;
   localparam int ARG_WIDTH   = 10;
   localparam int CSR_WIDTH   = 9;
   localparam int CALC_WIDTH  = 12;

   localparam int COLUMNS_RESET = 80;
   localparam int ROWS_RESET    = 24;

   typedef enum logic [3:0] {
      CMD_MOVE_TO         = 4'd0,
      CMD_MOVE_BY         = 4'd1,
      CMD_NEW_LINE        = 4'd2,
      CMD_CARRIAGE_RETURN = 4'd3,
      CMD_TAB             = 4'd4,
      CMD_SAVE            = 4'd5,
      CMD_RESTORE         = 4'd6,
      CMD_SET_MARGINS     = 4'd7,
      CMD_SET_MODE        = 4'd8,
      CMD_CLEAR_MODE      = 4'd9
   } command_type;

   typedef enum logic [1:0] {
      SCROLL_NONE   = 2'd0,
      SCROLL_PUSH   = 2'd1,
      SCROLL_REGION = 2'd2
   } scroll_event_type;

   localparam logic [1:0] MODE_INSERT  = 2'd0;
   localparam logic [1:0] MODE_NEWLINE = 2'd1;

   typedef enum logic [0:0] {
      CSR_SCREEN_COLUMNS = 1'b0,
      CSR_SCREEN_ROWS    = 1'b1
   } csr_index_type;

endpackage

// ===== rtl/tcc_req_if.sv =====
// ----------------------------------------------------------------------------
// Terminal cursor controller command channel
// Valid/ready channel carrying one decoded cursor command per beat.
// ----------------------------------------------------------------------------
interface tcc_req_if import tcc_pkg::*; ();
   logic                        valid;
   logic                        ready;
   logic [3:0]                  command;
   logic signed [ARG_WIDTH-1:0] arg_x;
   logic signed [ARG_WIDTH-1:0] arg_y;
   logic [1:0]                  which_mode;

   modport source (output valid, output command, output arg_x, output arg_y,
                   output which_mode, input ready);
   modport sink (input valid, input command, input arg_x, input arg_y,
                 input which_mode, output ready);
endinterface

// ===== rtl/tcc_rsp_if.sv =====
// ----------------------------------------------------------------------------
// Terminal cursor controller result channel
// Valid/ready channel carrying the caret, scroll event and modes per beat.
// ----------------------------------------------------------------------------
interface tcc_rsp_if import tcc_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [COL_WIDTH-1:0] caret_col;
   logic [ROW_WIDTH-1:0] caret_row;
   logic [1:0]           scroll_event;
   logic                 insert_on;
   logic                 newline_on;

   modport source (output valid, output caret_col, output caret_row,
                   output scroll_event, output insert_on, output newline_on,
                   input ready);
   modport sink (input valid, input caret_col, input caret_row,
                 input scroll_event, input insert_on, input newline_on,
                 output ready);
endinterface

// ===== rtl/terminal_cursor_controller_top.sv =====
// ----------------------------------------------------------------------------
// Terminal cursor controller
// Cursor, saved cursor, scroll margins and mode flags of a character terminal.
// ----------------------------------------------------------------------------
// Pipeline: a command beat passes through the input register, then the result
// register, before its result beat is offered.
// Throughput: one command per cycle unless the result stalls; cursor state
// updates as the command moves from the input into the result register.
// Reset: synchronous; empties both pipeline registers, homes the cursor,
// restores 80 columns by 24 rows with full-screen margins and clears modes.
module terminal_cursor_controller_top import tcc_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   tcc_req_if.sink              req_bus,
   tcc_rsp_if.source            rsp_bus,
   input  logic                 csr_we,
   input  logic [0:0]           csr_index,
   input  logic [CSR_WIDTH-1:0] csr_wdata
);

   // Configuration and cursor state
   logic [CSR_WIDTH-1:0] screen_columns_ff;
   logic [CSR_WIDTH-1:0] screen_rows_ff;
   logic [COL_WIDTH-1:0] cursor_col_ff, cursor_col_in;
   logic [ROW_WIDTH-1:0] cursor_row_ff, cursor_row_in;
   logic [COL_WIDTH-1:0] saved_col_ff, saved_col_in;
   logic [ROW_WIDTH-1:0] saved_row_ff, saved_row_in;
   logic [ROW_WIDTH-1:0] margin_top_ff, margin_top_in;
   logic [ROW_WIDTH-1:0] margin_bottom_ff, margin_bottom_in;
   logic                 insert_flag_ff, insert_flag_in;
   logic                 newline_flag_ff, newline_flag_in;

   // Input register
   logic                        in_valid_ff;
   logic [3:0]                  in_command_ff;
   logic signed [ARG_WIDTH-1:0] in_arg_x_ff;
   logic signed [ARG_WIDTH-1:0] in_arg_y_ff;
   logic [1:0]                  in_mode_ff;

   // Result register
   logic                 out_valid_ff;
   logic [COL_WIDTH-1:0] out_col_ff;
   logic [ROW_WIDTH-1:0] out_row_ff;
   scroll_event_type     out_event_ff, event_in;
   logic                 out_insert_ff;
   logic                 out_newline_ff;

   logic                 advance;
   logic [COL_WIDTH-1:0] cols_eff;
   logic [ROW_WIDTH-1:0] rows_last;
   logic [ROW_WIDTH-1:0] csr_rows_last;

   logic                         do_move;
   logic signed [CALC_WIDTH-1:0] mv_x, mv_y, lim_x, lim_y, stop_lo, stop_hi;
   logic signed [CALC_WIDTH-1:0] top_val, bot_val, last_s;
   logic [COL_WIDTH-1:0]         col_base;

   // Last usable row index for a rows register value saturated to 1..MAX_ROWS.
   function automatic logic [ROW_WIDTH-1:0] last_row(input logic [CSR_WIDTH-1:0] rows);
      logic [ROW_WIDTH-1:0] res;
      if (rows == '0) begin
         res = '0;
      end else if (rows > CSR_WIDTH'(MAX_ROWS)) begin
         res = ROW_WIDTH'(MAX_ROWS - 1);
      end else begin
         res = ROW_WIDTH'(rows - 1'b1);
      end
      return res;
   endfunction

   // Lower bound first, then upper bound.
   function automatic logic signed [CALC_WIDTH-1:0] clamp(
      input logic signed [CALC_WIDTH-1:0] v,
      input logic signed [CALC_WIDTH-1:0] lo,
      input logic signed [CALC_WIDTH-1:0] hi);
      logic signed [CALC_WIDTH-1:0] res;
      res = (v < lo) ? lo : v;
      res = (res > hi) ? hi : res;
      return res;
   endfunction

   assign cols_eff = (screen_columns_ff > COL_WIDTH'(MAX_COLUMNS)) ?
                     COL_WIDTH'(MAX_COLUMNS) : screen_columns_ff;
   assign rows_last     = last_row(screen_rows_ff);
   assign csr_rows_last = last_row(csr_wdata);
   assign last_s        = $signed({{(CALC_WIDTH-ROW_WIDTH){1'b0}}, rows_last});

   assign advance       = in_valid_ff && (!out_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !in_valid_ff || advance;

   always_comb begin
      cursor_col_in    = cursor_col_ff;
      cursor_row_in    = cursor_row_ff;
      saved_col_in     = saved_col_ff;
      saved_row_in     = saved_row_ff;
      margin_top_in    = margin_top_ff;
      margin_bottom_in = margin_bottom_ff;
      insert_flag_in   = insert_flag_ff;
      newline_flag_in  = newline_flag_ff;
      event_in         = SCROLL_NONE;
      do_move          = 1'b0;
      mv_x             = $signed({{(CALC_WIDTH-COL_WIDTH){1'b0}}, cursor_col_ff});
      mv_y             = $signed({{(CALC_WIDTH-ROW_WIDTH){1'b0}}, cursor_row_ff});
      col_base         = newline_flag_ff ? '0 : cursor_col_ff;
      top_val          = {{(CALC_WIDTH-ARG_WIDTH){in_arg_x_ff[ARG_WIDTH-1]}}, in_arg_x_ff}
                         - CALC_WIDTH'(1);
      bot_val          = {{(CALC_WIDTH-ARG_WIDTH){in_arg_y_ff[ARG_WIDTH-1]}}, in_arg_y_ff}
                         - CALC_WIDTH'(1);

      unique case (in_command_ff)
         CMD_MOVE_TO: begin
            do_move = 1'b1;
            mv_x    = {{(CALC_WIDTH-ARG_WIDTH){in_arg_x_ff[ARG_WIDTH-1]}}, in_arg_x_ff};
            mv_y    = {{(CALC_WIDTH-ARG_WIDTH){in_arg_y_ff[ARG_WIDTH-1]}}, in_arg_y_ff};
         end
         CMD_MOVE_BY: begin
            do_move = 1'b1;
            mv_x    = $signed({{(CALC_WIDTH-COL_WIDTH){1'b0}}, cursor_col_ff})
                      + {{(CALC_WIDTH-ARG_WIDTH){in_arg_x_ff[ARG_WIDTH-1]}}, in_arg_x_ff};
            mv_y    = $signed({{(CALC_WIDTH-ROW_WIDTH){1'b0}}, cursor_row_ff})
                      + {{(CALC_WIDTH-ARG_WIDTH){in_arg_y_ff[ARG_WIDTH-1]}}, in_arg_y_ff};
         end
         CMD_NEW_LINE: begin
            // Newline mode returns the column before the line feed.
            cursor_col_in = col_base;
            mv_x = $signed({{(CALC_WIDTH-COL_WIDTH){1'b0}}, col_base});
            mv_y = $signed({{(CALC_WIDTH-ROW_WIDTH){1'b0}}, cursor_row_ff})
                   + CALC_WIDTH'(1);
            if (cursor_row_ff == margin_bottom_ff) begin
               event_in = (margin_bottom_ff == rows_last) ? SCROLL_PUSH : SCROLL_REGION;
            end else if (cursor_row_ff < rows_last) begin
               do_move = 1'b1;
            end
         end
         CMD_CARRIAGE_RETURN: begin
            cursor_col_in = '0;
         end
         CMD_TAB: begin
            do_move = 1'b1;
            mv_x    = $signed(CALC_WIDTH'((32'(cursor_col_ff) / TAB_STEP + 1) * TAB_STEP));
         end
         CMD_SAVE: begin
            saved_col_in = cursor_col_ff;
            saved_row_in = cursor_row_ff;
         end
         CMD_RESTORE: begin
            do_move = 1'b1;
            mv_x    = $signed({{(CALC_WIDTH-COL_WIDTH){1'b0}}, saved_col_ff});
            mv_y    = $signed({{(CALC_WIDTH-ROW_WIDTH){1'b0}}, saved_row_ff});
         end
         CMD_SET_MARGINS: begin
            margin_top_in    = ROW_WIDTH'(clamp(top_val, '0, last_s));
            margin_bottom_in = ROW_WIDTH'(clamp(bot_val, '0, last_s));
         end
         CMD_SET_MODE, CMD_CLEAR_MODE: begin
            if (in_mode_ff == MODE_INSERT) begin
               insert_flag_in = (in_command_ff == CMD_SET_MODE);
            end else if (in_mode_ff == MODE_NEWLINE) begin
               newline_flag_in = (in_command_ff == CMD_SET_MODE);
            end
         end
         default: begin
         end
      endcase

      // A cursor outside the scroll region is bounded by the screen edge on
      // that side instead of the margin.
      stop_lo = (cursor_row_ff < margin_top_ff) ? '0 :
                $signed({{(CALC_WIDTH-ROW_WIDTH){1'b0}}, margin_top_ff});
      stop_hi = (cursor_row_ff > margin_bottom_ff) ? last_s :
                $signed({{(CALC_WIDTH-ROW_WIDTH){1'b0}}, margin_bottom_ff});
      lim_x   = clamp(mv_x, '0, $signed({{(CALC_WIDTH-COL_WIDTH){1'b0}}, cols_eff}));
      lim_y   = clamp(mv_y, stop_lo, stop_hi);
      if (do_move) begin
         cursor_col_in = COL_WIDTH'(lim_x);
         cursor_row_in = ROW_WIDTH'(lim_y);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         screen_columns_ff <= CSR_WIDTH'(COLUMNS_RESET);
         screen_rows_ff    <= CSR_WIDTH'(ROWS_RESET);
         cursor_col_ff     <= '0;
         cursor_row_ff     <= '0;
         saved_col_ff      <= '0;
         saved_row_ff      <= '0;
         margin_top_ff     <= '0;
         margin_bottom_ff  <= ROW_WIDTH'(ROWS_RESET - 1);
         insert_flag_ff    <= 1'b0;
         newline_flag_ff   <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_SCREEN_COLUMNS: begin
               screen_columns_ff <= csr_wdata;
            end
            CSR_SCREEN_ROWS: begin
               screen_rows_ff <= csr_wdata;
               // A row count that changes the last row resets the margins to the full screen.
               if (csr_rows_last != rows_last) begin
                  margin_top_ff    <= '0;
                  margin_bottom_ff <= csr_rows_last;
                  if (cursor_row_ff > csr_rows_last) begin
                     cursor_row_ff <= csr_rows_last;
                  end
               end
            end
            default: begin
            end
         endcase
      end else if (advance) begin
         cursor_col_ff    <= cursor_col_in;
         cursor_row_ff    <= cursor_row_in;
         saved_col_ff     <= saved_col_in;
         saved_row_ff     <= saved_row_in;
         margin_top_ff    <= margin_top_in;
         margin_bottom_ff <= margin_bottom_in;
         insert_flag_ff   <= insert_flag_in;
         newline_flag_ff  <= newline_flag_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_bus.ready) begin
            in_valid_ff <= req_bus.valid;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_bus.valid && req_bus.ready) begin
         in_command_ff <= req_bus.command;
         in_arg_x_ff   <= req_bus.arg_x;
         in_arg_y_ff   <= req_bus.arg_y;
         in_mode_ff    <= req_bus.which_mode;
      end
      if (advance) begin
         out_col_ff     <= cursor_col_in;
         out_row_ff     <= cursor_row_in;
         out_event_ff   <= event_in;
         out_insert_ff  <= insert_flag_in;
         out_newline_ff <= newline_flag_in;
      end
   end

   assign rsp_bus.valid        = out_valid_ff;
   assign rsp_bus.caret_col    = out_col_ff;
   assign rsp_bus.caret_row    = out_row_ff;
   assign rsp_bus.scroll_event = out_event_ff;
   assign rsp_bus.insert_on    = out_insert_ff;
   assign rsp_bus.newline_on   = out_newline_ff;

endmodule

// ===== rtl/tcc_checker.sv =====
// ----------------------------------------------------------------------------
// Terminal cursor controller checker
// Port-level checks on beat ordering and result stability, bound to the top.
// ----------------------------------------------------------------------------
module tcc_checker import tcc_pkg::*; (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input logic [COL_WIDTH-1:0] caret_col,
   input logic [ROW_WIDTH-1:0] caret_row,
   input logic [1:0]           scroll_event,
   input logic                 insert_on,
   input logic                 newline_on
);

   // Commands accepted whose result beat has not been taken yet.
   logic [2:0] pending_ff, pending_in;

   always_comb begin
      pending_in = pending_ff;
      if (req_valid && req_ready) begin
         pending_in = pending_in + 3'd1;
      end
      if (rsp_valid && rsp_ready) begin
         pending_in = pending_in - 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   a_pending_bound: assert property (@(posedge clock) disable iff (reset)
      pending_ff <= 3'd2)
      else $error("more than two commands outstanding");

   a_no_spurious_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pending_ff != 3'd0)
      else $error("result beat without an accepted command");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(caret_col) &&
         $stable(caret_row) && $stable(scroll_event) && $stable(insert_on) &&
         $stable(newline_on))
      else $error("stalled result beat changed");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result beat right after reset");

endmodule

bind terminal_cursor_controller_top tcc_checker u_tcc_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_bus.valid),
   .req_ready    (req_bus.ready),
   .rsp_valid    (rsp_bus.valid),
   .rsp_ready    (rsp_bus.ready),
   .caret_col    (rsp_bus.caret_col),
   .caret_row    (rsp_bus.caret_row),
   .scroll_event (rsp_bus.scroll_event),
   .insert_on    (rsp_bus.insert_on),
   .newline_on   (rsp_bus.newline_on)
);
